// ===== sv/ftn_pkg.sv =====
// Shared types and constants for the flat triangle normal expander.
package ftn_pkg;

    // Default corner coordinate width (signed Q8.8)
    localparam int COORD_WIDTH_DEF = 16;
    // Widest edge component handled exactly; wider edges drop low bits
    localparam int EDGE_MAX_W = 30;

    // The largest normalized magnitude sits in [2^22, 2^23)
    localparam int NORM_TOP = 22;
    localparam int MAG_W    = 23;
    // Sum of three squared magnitudes, root, divider widths
    localparam int SUM_W    = 48;
    localparam int ROOT_W   = 24;
    localparam int ROOT_IT  = 24;
    localparam int NUM_W    = 40;
    localparam int QUO_W    = 16;
    localparam int FRAC_SH  = 15;
    localparam int OUT_W    = 16;

    localparam logic [QUO_W-1:0] NORM_ONE = 16'd16384;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH_DEF = 2;

    typedef enum logic [1:0] {
        F_IDLE,
        F_MUL,
        F_PUSH
    } ftn_front_state_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_NORM,
        B_SQUARE,
        B_ROOT,
        B_DIVIDE,
        B_SIGN,
        B_EMIT
    } ftn_back_state_t;

    // Status from the queue to its neighbors
    typedef struct packed {
        logic full;
        logic empty;
    } ftn_queue_status_t;

endpackage

// ===== sv/flat_triangle_normal_expander.sv =====
// Top level: triangle in, three vertices with a shared face normal out.
//
// Input channel: one triangle (corners A, B, C, signed Q8.8) per transaction,
// taken when push is high and full is low. Output channel: three vertex
// transactions per triangle in order A, B, C; a result is on the ports while
// empty is low and is taken when pop is high. Each carries the unit normal
// (signed Q1.14), a running 16-bit vertex number and degenerate/last flags.
// Front: edges at accept, cross product on one shared multiplier.
// A two-entry queue separates it from the back, so the front keeps taking
// triangles while the back or the receiver stalls, until the queue fills.
// Back: pick-up, normalize shift (shift by four then by one), squares,
// bit-serial square root, three parallel dividers, sign, then three vertex
// transactions. The back picks up a new triangle only after the third
// vertex of the last one is taken.
// A degenerate triangle skips the math and goes from its pick-up straight to
// its three vertex transactions.
// Reset clears the vertex number to zero and empties both sides.
// A stalled receiver holds the current vertex; no result is dropped.
module flat_triangle_normal_expander
    import ftn_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    output logic                   full,
    input  logic [COORD_WIDTH-1:0] corner_a_x,
    input  logic [COORD_WIDTH-1:0] corner_a_y,
    input  logic [COORD_WIDTH-1:0] corner_a_z,
    input  logic [COORD_WIDTH-1:0] corner_b_x,
    input  logic [COORD_WIDTH-1:0] corner_b_y,
    input  logic [COORD_WIDTH-1:0] corner_b_z,
    input  logic [COORD_WIDTH-1:0] corner_c_x,
    input  logic [COORD_WIDTH-1:0] corner_c_y,
    input  logic [COORD_WIDTH-1:0] corner_c_z,
    output logic                   empty,
    input  logic                   pop,
    output logic [OUT_W-1:0]       pos_x,
    output logic [OUT_W-1:0]       pos_y,
    output logic [OUT_W-1:0]       pos_z,
    output logic [OUT_W-1:0]       norm_x,
    output logic [OUT_W-1:0]       norm_y,
    output logic [OUT_W-1:0]       norm_z,
    output logic [OUT_W-1:0]       vertex_number,
    output logic                   degenerate,
    output logic                   last
);

    localparam int EW  = COORD_WIDTH + 1;
    localparam int EDW = (EW > EDGE_MAX_W) ? EDGE_MAX_W : EW;
    localparam int QW  = 9*COORD_WIDTH + 3 + 3*(2*EDW);

    logic [9*COORD_WIDTH-1:0] corners;
    logic                     q_push;
    logic                     q_pop;
    logic [QW-1:0]            q_wdata;
    logic [QW-1:0]            q_rdata;
    ftn_queue_status_t        q_status;

    assign corners = {corner_c_z, corner_c_y, corner_c_x,
                      corner_b_z, corner_b_y, corner_b_x,
                      corner_a_z, corner_a_y, corner_a_x};

    ftn_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .corners  (corners),
        .q_push   (q_push),
        .q_data   (q_wdata),
        .q_status (q_status)
    );

    ftn_fifo #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH_DEF)) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_wdata),
        .rd_en   (q_pop),
        .rd_data (q_rdata),
        .status  (q_status)
    );

    ftn_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_status      (q_status),
        .q_data        (q_rdata),
        .q_pop         (q_pop),
        .empty         (empty),
        .pop           (pop),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .pos_z         (pos_z),
        .norm_x        (norm_x),
        .norm_y        (norm_y),
        .norm_z        (norm_z),
        .vertex_number (vertex_number),
        .degenerate    (degenerate),
        .last          (last)
    );

endmodule

// ===== sv/ftn_fifo.sv =====
// Small flop-based queue between the front and the back.
module ftn_fifo
    import ftn_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output ftn_queue_status_t status
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             do_wr;
    logic             do_rd;

    assign status.full  = (count_reg == CW'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_wr = wr_en && !status.full;
    assign do_rd = rd_en && !status.empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== sv/ftn_front.sv =====
// Front: takes a triangle, forms edges and the cross product on one multiplier.
module ftn_front
    import ftn_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [9*COORD_WIDTH-1:0]    corners,
    output logic                        q_push,
    output logic [9*COORD_WIDTH+3+3*(2*((COORD_WIDTH+1 > EDGE_MAX_W) ? EDGE_MAX_W
                                         : COORD_WIDTH+1))-1:0] q_data,
    input  ftn_queue_status_t           q_status
);

    localparam int CW  = COORD_WIDTH;
    localparam int EW  = CW + 1;
    localparam int PRE = (EW > EDGE_MAX_W) ? (EW - EDGE_MAX_W) : 0;
    localparam int EDW = EW - PRE;
    localparam int PW  = 2 * EDW;
    localparam int MW  = 2 * EDW;

    ftn_front_state_t state_reg, state_next;

    logic [9*CW-1:0]        corners_reg;
    logic signed [EDW-1:0]  e1_reg [3];
    logic signed [EDW-1:0]  e2_reg [3];
    logic signed [EDW-1:0]  e1_new [3];
    logic signed [EDW-1:0]  e2_new [3];
    logic [2:0]             step_reg;
    logic signed [PW-1:0]   prod_reg;
    logic signed [PW-1:0]   acc_reg;
    logic signed [PW:0]     diff;
    logic [MW-1:0]          mag_reg [3];
    logic [2:0]             neg_reg;
    logic signed [EDW-1:0]  op_a;
    logic signed [EDW-1:0]  op_b;
    logic                   accept;

    assign accept = push && !full;

    // Edge components from the incoming corners
    always_comb
    begin
        logic signed [CW:0] da;
        logic signed [CW:0] db;
        logic signed [CW:0] dc;
        for (int i = 0; i < 3; i++)
        begin
            da = $signed({corners[i*CW + CW-1], corners[i*CW +: CW]});
            db = $signed({corners[(3+i)*CW + CW-1], corners[(3+i)*CW +: CW]});
            dc = $signed({corners[(6+i)*CW + CW-1], corners[(6+i)*CW +: CW]});
            e1_new[i] = EDW'((db - da) >>> PRE);
            e2_new[i] = EDW'((dc - da) >>> PRE);
        end
    end

    // Operand select for the shared multiplier
    always_comb
    begin
        case (step_reg)
            3'd0:    begin op_a = e1_reg[1]; op_b = e2_reg[2]; end
            3'd1:    begin op_a = e1_reg[2]; op_b = e2_reg[1]; end
            3'd2:    begin op_a = e1_reg[2]; op_b = e2_reg[0]; end
            3'd3:    begin op_a = e1_reg[0]; op_b = e2_reg[2]; end
            3'd4:    begin op_a = e1_reg[0]; op_b = e2_reg[1]; end
            3'd5:    begin op_a = e1_reg[1]; op_b = e2_reg[0]; end
            default: begin op_a = '0;        op_b = '0;        end
        endcase
    end

    assign diff = (PW+1)'(acc_reg) - (PW+1)'(prod_reg);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE:  if (accept) state_next = F_MUL;
            F_MUL:   if (step_reg == 3'd6) state_next = F_PUSH;
            F_PUSH:  if (!q_status.full) state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        full   = (state_reg != F_IDLE);
        q_push = (state_reg == F_PUSH) && !q_status.full;
        q_data = {corners_reg, neg_reg, mag_reg[2], mag_reg[1], mag_reg[0]};
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == F_MUL)
            begin
                step_reg <= step_reg + 1'b1;
            end
            else
            begin
                step_reg <= '0;
            end
        end
    end

    // Datapath: products, accumulate and split into sign and magnitude
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            corners_reg <= corners;
            e1_reg <= e1_new;
            e2_reg <= e2_new;
        end
        if (state_reg == F_MUL)
        begin
            prod_reg <= PW'(op_a * op_b);
            if (step_reg != 3'd0)
            begin
                if (step_reg[0])
                begin
                    acc_reg <= prod_reg;
                end
                else
                begin
                    neg_reg[step_reg[2:1] - 2'd1] <= diff[PW];
                    mag_reg[step_reg[2:1] - 2'd1] <= diff[PW] ? MW'(-diff) : MW'(diff);
                end
            end
        end
    end

endmodule

// ===== sv/ftn_back.sv =====
// Back: scales the cross product to a unit normal and emits three vertices.
module ftn_back
    import ftn_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  ftn_queue_status_t    q_status,
    input  logic [9*COORD_WIDTH+3+3*(2*((COORD_WIDTH+1 > EDGE_MAX_W) ? EDGE_MAX_W
                                         : COORD_WIDTH+1))-1:0] q_data,
    output logic                 q_pop,
    output logic                 empty,
    input  logic                 pop,
    output logic [OUT_W-1:0]     pos_x,
    output logic [OUT_W-1:0]     pos_y,
    output logic [OUT_W-1:0]     pos_z,
    output logic [OUT_W-1:0]     norm_x,
    output logic [OUT_W-1:0]     norm_y,
    output logic [OUT_W-1:0]     norm_z,
    output logic [OUT_W-1:0]     vertex_number,
    output logic                 degenerate,
    output logic                 last
);

    localparam int CW  = COORD_WIDTH;
    localparam int EW  = CW + 1;
    localparam int PRE = (EW > EDGE_MAX_W) ? (EW - EDGE_MAX_W) : 0;
    localparam int EDW = EW - PRE;
    localparam int MW  = 2 * EDW;
    localparam int NW  = (MW > MAG_W) ? MW : MAG_W;
    localparam int RW  = SUM_W + 1;

    ftn_back_state_t state_reg, state_next;

    logic [9*CW-1:0]    corners_reg;
    logic [2:0]         neg_reg;
    logic               degen_reg;
    logic [NW-1:0]      mag_reg [3];
    logic [NW-1:0]      mag_or;
    logic               norm_done;
    logic [SUM_W-1:0]   s_reg;
    logic [RW-1:0]      r_reg;
    logic [SUM_W-1:0]   bit_reg;
    logic [RW-1:0]      r_try;
    logic [NUM_W-1:0]   num_reg [3];
    logic [NUM_W-1:0]   dsh_reg;
    logic [QUO_W-1:0]   q_reg [3];
    logic [OUT_W-1:0]   nrm_reg [3];
    logic [4:0]         cnt_reg;
    logic [1:0]         k_reg;
    logic [OUT_W-1:0]   vcount_reg;
    logic [2*MAG_W-1:0] square;
    logic               emit_take;

    assign mag_or    = mag_reg[0] | mag_reg[1] | mag_reg[2];
    assign norm_done = ((mag_or >> NORM_TOP) == NW'(1));
    assign r_try     = r_reg + RW'(bit_reg);
    assign square    = mag_reg[cnt_reg[1:0]][MAG_W-1:0] * mag_reg[cnt_reg[1:0]][MAG_W-1:0];
    assign emit_take = (state_reg == B_EMIT) && pop;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
                if (!q_status.empty)
                begin
                    state_next = (q_data[3*MW +: 3] == 3'b000 &&
                                  q_data[3*MW-1:0] == '0) ? B_EMIT : B_NORM;
                end
            B_NORM:   if (norm_done) state_next = B_SQUARE;
            B_SQUARE: if (cnt_reg == 5'd2) state_next = B_ROOT;
            B_ROOT:   if (cnt_reg == 5'(ROOT_IT - 1)) state_next = B_DIVIDE;
            B_DIVIDE: if (cnt_reg == 5'(QUO_W - 1)) state_next = B_SIGN;
            B_SIGN:   state_next = B_EMIT;
            B_EMIT:   if (pop && k_reg == 2'd2) state_next = B_IDLE;
            default:  state_next = B_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        q_pop         = (state_reg == B_IDLE) && !q_status.empty;
        empty         = (state_reg != B_EMIT);
        pos_x         = OUT_W'(corners_reg[(3*k_reg)*CW +: CW]);
        pos_y         = OUT_W'(corners_reg[(3*k_reg+1)*CW +: CW]);
        pos_z         = OUT_W'(corners_reg[(3*k_reg+2)*CW +: CW]);
        norm_x        = nrm_reg[0];
        norm_y        = nrm_reg[1];
        norm_z        = nrm_reg[2];
        vertex_number = vcount_reg;
        degenerate    = degen_reg;
        last          = (k_reg == 2'd2);
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= B_IDLE;
            cnt_reg    <= '0;
            k_reg      <= '0;
            vcount_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_next != state_reg)
            begin
                cnt_reg <= '0;
            end
            else
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (emit_take)
            begin
                vcount_reg <= vcount_reg + 1'b1;
                k_reg      <= (k_reg == 2'd2) ? 2'd0 : k_reg + 1'b1;
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            B_IDLE:
                if (!q_status.empty)
                begin
                    corners_reg <= q_data[3*MW+3 +: 9*CW];
                    neg_reg     <= q_data[3*MW +: 3];
                    degen_reg   <= (q_data[3*MW-1:0] == '0);
                    for (int i = 0; i < 3; i++)
                    begin
                        mag_reg[i] <= NW'(q_data[i*MW +: MW]);
                        nrm_reg[i] <= '0;
                    end
                    s_reg <= '0;
                end
            B_NORM:
                for (int i = 0; i < 3; i++)
                begin
                    // Coarse then fine shifts toward the target bit
                    if ((mag_or >> (NORM_TOP + 5)) != '0)
                        mag_reg[i] <= mag_reg[i] >> 4;
                    else if ((mag_or >> (NORM_TOP + 1)) != '0)
                        mag_reg[i] <= mag_reg[i] >> 1;
                    else if ((mag_or >> (NORM_TOP - 3)) == '0)
                        mag_reg[i] <= mag_reg[i] << 4;
                    else if ((mag_or >> NORM_TOP) == '0)
                        mag_reg[i] <= mag_reg[i] << 1;
                end
            B_SQUARE:
            begin
                s_reg <= s_reg + SUM_W'(square);
                if (cnt_reg == 5'd2)
                begin
                    r_reg   <= '0;
                    bit_reg <= SUM_W'(1) << (SUM_W - 2);
                end
            end
            B_ROOT:
            begin
                // One result bit per cycle
                if (RW'(s_reg) >= r_try)
                begin
                    s_reg <= s_reg - SUM_W'(r_try);
                    r_reg <= (r_reg >> 1) + RW'(bit_reg);
                end
                else
                begin
                    r_reg <= r_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
            B_DIVIDE:
            begin
                if (cnt_reg == 5'd0)
                begin
                    // Dividend with the rounding term folded in; divisor is twice the root,
                    // lined up with quotient bit 14 (the quotient never exceeds 16384)
                    for (int i = 0; i < 3; i++)
                    begin
                        num_reg[i] <= (NUM_W'(mag_reg[i][MAG_W-1:0]) << FRAC_SH)
                                      + NUM_W'(r_reg[ROOT_W-1:0]);
                        q_reg[i]   <= '0;
                    end
                    dsh_reg <= NUM_W'(r_reg[ROOT_W-1:0]) << (QUO_W - 1);
                end
                else
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        if (num_reg[i] >= dsh_reg)
                        begin
                            num_reg[i] <= num_reg[i] - dsh_reg;
                            q_reg[i]   <= {q_reg[i][QUO_W-2:0], 1'b1};
                        end
                        else
                        begin
                            q_reg[i]   <= {q_reg[i][QUO_W-2:0], 1'b0};
                        end
                    end
                    dsh_reg <= dsh_reg >> 1;
                end
            end
            B_SIGN:
                for (int i = 0; i < 3; i++)
                begin
                    logic [QUO_W-1:0] qc;
                    qc = (q_reg[i] > NORM_ONE) ? NORM_ONE : q_reg[i];
                    nrm_reg[i] <= neg_reg[i] ? OUT_W'(-qc) : OUT_W'(qc);
                end
            default:
            begin
            end
        endcase
    end

    // A degenerate triangle always carries a zero normal
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && degenerate) |-> (norm_x == '0 && norm_y == '0 && norm_z == '0))
        else $error("degenerate vertex with nonzero normal");

    // Normal components never exceed one in magnitude
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> ($signed(norm_x) <= 16384 && $signed(norm_x) >= -16384 &&
                    $signed(norm_y) <= 16384 && $signed(norm_y) >= -16384 &&
                    $signed(norm_z) <= 16384 && $signed(norm_z) >= -16384))
        else $error("normal component out of range");

    // Taking the third vertex ends the triangle
    assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !empty && last) |=> empty)
        else $error("results continue after last vertex");

endmodule

// ===== sim/flat_triangle_normal_expander_tb.sv =====
// Testbench for the flat triangle normal expander: directed and random triangles checked against a face normal predictor.
`timescale 1ns / 1ps

module flat_triangle_normal_expander_tb;
    import ftn_pkg::*;

    localparam int CW = COORD_WIDTH_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_TRIANGLES = 150;

    // One emitted vertex
    typedef struct packed {
        logic [15:0] px, py, pz;
        logic [15:0] nx, ny, nz;
        logic [15:0] vnum;
        logic        degen;
        logic        lst;
    } vertex_t;

    typedef logic [CW-1:0] corner_set_t [9];

    // Directed row: corners, and for rows with an obvious normal the typed-in value
    typedef struct {
        logic [CW-1:0] crd [9];
        bit            typed;
        logic [15:0]   enx, eny, enz;
        logic          edeg;
    } directed_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic push = 1'b0;
    logic pop = 1'b0;
    logic full, empty;
    logic [CW-1:0] crd [9];
    logic [15:0] pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, vertex_number;
    logic degenerate, last;

    vertex_t       expected_vertices [$];
    logic [15:0]   vertex_count;
    int            mismatches = 0;
    int            cycles = 0;
    int            pop_hold = 0;
    directed_row_t directed_rows [$];

    always #6 clk = ~clk;

    flat_triangle_normal_expander dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .corner_a_x(crd[0]), .corner_a_y(crd[1]), .corner_a_z(crd[2]),
        .corner_b_x(crd[3]), .corner_b_y(crd[4]), .corner_b_z(crd[5]),
        .corner_c_x(crd[6]), .corner_c_y(crd[7]), .corner_c_z(crd[8]),
        .empty(empty), .pop(pop),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .norm_x(norm_x), .norm_y(norm_y), .norm_z(norm_z),
        .vertex_number(vertex_number), .degenerate(degenerate), .last(last)
    );

    // Integer square root, floor
    function automatic longint unsigned isqrt(longint unsigned s);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > s)
            b >>= 2;
        while (b != 0)
        begin
            if (s >= r + b)
            begin
                s -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    // Face normal in Q1.14 from three corners; returns degenerate flag
    function automatic logic face_normal(input corner_set_t c, output logic [15:0] n [3]);
        longint e1 [3];
        longint e2 [3];
        longint cr [3];
        longint unsigned mg [3];
        longint unsigned m, s, r, q;
        bit ng [3];
        int p;
        for (int i = 0; i < 3; i++)
        begin
            e1[i] = longint'(signed'(c[3+i])) - longint'(signed'(c[i]));
            e2[i] = longint'(signed'(c[6+i])) - longint'(signed'(c[i]));
        end
        cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
        cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
        cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
        for (int i = 0; i < 3; i++)
        begin
            ng[i] = cr[i] < 0;
            mg[i] = ng[i] ? -cr[i] : cr[i];
            n[i] = '0;
        end
        if ((mg[0] | mg[1] | mg[2]) == 0)
            return 1'b1;
        m = mg[0];
        if (mg[1] > m) m = mg[1];
        if (mg[2] > m) m = mg[2];
        p = 0;
        while (m > 1)
        begin
            m >>= 1;
            p++;
        end
        for (int i = 0; i < 3; i++)
            mg[i] = (p > NORM_TOP) ? (mg[i] >> (p - NORM_TOP)) : (mg[i] << (NORM_TOP - p));
        s = mg[0] * mg[0] + mg[1] * mg[1] + mg[2] * mg[2];
        r = isqrt(s);
        for (int i = 0; i < 3; i++)
        begin
            q = (2 * mg[i] * 16384 + r) / (2 * r);
            if (q > 16384)
                q = 16384;
            n[i] = ng[i] ? 16'(17'h10000 - q) : 16'(q);
        end
        return 1'b0;
    endfunction

    // Queue the three expected vertices of one accepted triangle
    task automatic expect_triangle(input corner_set_t c, input directed_row_t row,
                                   input bit use_row);
        logic [15:0] n [3];
        logic dg;
        vertex_t v;
        dg = face_normal(c, n);
        if (use_row && row.typed)
        begin
            n[0] = row.enx;
            n[1] = row.eny;
            n[2] = row.enz;
            dg = row.edeg;
        end
        for (int k = 0; k < 3; k++)
        begin
            v.px = 16'(c[3*k]);
            v.py = 16'(c[3*k+1]);
            v.pz = 16'(c[3*k+2]);
            v.nx = n[0];
            v.ny = n[1];
            v.nz = n[2];
            v.vnum = vertex_count;
            v.degen = dg;
            v.lst = (k == 2);
            expected_vertices.push_back(v);
            vertex_count++;
        end
    endtask

    // Present one triangle and wait for the transaction; push stays high afterwards
    // so that a back-to-back triangle can follow without a gap when the next gap is zero
    task automatic send_triangle(input corner_set_t c, input directed_row_t row,
                                 input bit use_row);
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap != 0)
        begin
            push <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        push <= 1'b1;
        foreach (crd[i])
            crd[i] <= c[i];
        @(posedge clk);
        while (full)
            @(posedge clk);
        expect_triangle(c, row, use_row);
        @(negedge clk);
    endtask

    task automatic add_row(input logic [CW-1:0] a [9], input bit typed,
                           input logic [15:0] x, y, z, input logic dg);
        directed_row_t r;
        r.crd = a;
        r.typed = typed;
        r.enx = x;
        r.eny = y;
        r.enz = z;
        r.edeg = dg;
        directed_rows.push_back(r);
    endtask

    // Receiver: random pop gaps, now and then a long stall
    always @(negedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else if (pop_hold > 0)
        begin
            pop_hold = pop_hold - 1;
            pop <= 1'b0;
        end
        else if ($urandom_range(0, 39) == 0)
        begin
            pop_hold = $urandom_range(10, 40);
            pop <= 1'b0;
        end
        else if ($urandom_range(0, 19) == 0)
            pop <= 1'b0;
        else if ($urandom_range(0, 2) == 0)
            pop <= ($urandom_range(0, 3) != 0);
        else
            pop <= 1'b1;
    end

    // Compare each taken vertex at the rising edge
    always @(posedge clk)
    begin
        vertex_t got;
        vertex_t exp_v;
        cycles <= cycles + 1;
        if (rst_n && pop && !empty)
        begin
            got = '{pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, vertex_number,
                    degenerate, last};
            if (expected_vertices.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected vertex transaction %h", got);
            end
            else
            begin
                exp_v = expected_vertices.pop_front();
                if (got !== exp_v)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("vertex mismatch: expected %h got %h", exp_v, got);
                end
            end
        end
    end

    // Timeout guard
    always @(posedge clk)
    begin
        if (cycles > CYCLE_LIMIT)
        begin
            $display("flat_triangle_normal_expander verification failed");
            $finish;
        end
    end

    initial
    begin
        logic [CW-1:0] a [9];
        corner_set_t c;
        directed_row_t none;
        int cls;
        logic [CW-1:0] base;
        foreach (crd[i])
            crd[i] = '0;
        vertex_count = '0;
        none.typed = 1'b0;
        none.crd = '{default: '0};

        // Directed rows: zero triangle, axis normals, extremes, collinear, coincident, tiny and mixed
        a = '{default: '0};
        add_row(a, 1'b1, 16'd0, 16'd0, 16'd0, 1'b1);
        a = '{16'd0, 16'd0, 16'd0, 16'h0100, 16'd0, 16'd0, 16'd0, 16'h0100, 16'd0};
        add_row(a, 1'b1, 16'd0, 16'd0, 16'd16384, 1'b0);
        a = '{16'd0, 16'd0, 16'd0, 16'd0, 16'h0100, 16'd0, 16'h0100, 16'd0, 16'd0};
        add_row(a, 1'b1, 16'd0, 16'd0, 16'hC000, 1'b0);
        a = '{16'd0, 16'd0, 16'd0, 16'd0, 16'h0100, 16'd0, 16'd0, 16'd0, 16'h0100};
        add_row(a, 1'b1, 16'd16384, 16'd0, 16'd0, 1'b0);
        a = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'h0100, 16'h0100, 16'd0, 16'd0};
        add_row(a, 1'b1, 16'd0, 16'd16384, 16'd0, 1'b0);
        a = '{16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h8000, 16'h8000,
              16'h8000, 16'h7FFF, 16'h8000};
        add_row(a, 1'b1, 16'd0, 16'd0, 16'd16384, 1'b0);
        a = '{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF,
              16'h7FFF, 16'h7FFF, 16'h8000};
        add_row(a, 1'b0, 16'd0, 16'd0, 16'd0, 1'b0);
        a = '{16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF,
              16'h8000, 16'h8000, 16'h7FFF};
        add_row(a, 1'b0, 16'd0, 16'd0, 16'd0, 1'b0);
        a = '{16'h0001, 16'h0002, 16'h0003, 16'h0002, 16'h0004, 16'h0006,
              16'h0003, 16'h0006, 16'h0009};
        add_row(a, 1'b1, 16'd0, 16'd0, 16'd0, 1'b1);
        a = '{16'h1234, 16'h5678, 16'h9ABC, 16'h1234, 16'h5678, 16'h9ABC,
              16'h1234, 16'h5678, 16'h9ABC};
        add_row(a, 1'b1, 16'd0, 16'd0, 16'd0, 1'b1);
        a = '{16'd0, 16'd0, 16'd0, 16'd1, 16'd0, 16'd0, 16'd0, 16'd1, 16'd0};
        add_row(a, 1'b1, 16'd0, 16'd0, 16'd16384, 1'b0);
        a = '{16'd0, 16'd0, 16'd0, 16'd1, 16'd1, 16'd0, 16'd0, 16'd1, 16'd1};
        add_row(a, 1'b0, 16'd0, 16'd0, 16'd0, 1'b0);
        a = '{16'hFFFF, 16'h5555, 16'hAAAA, 16'h0000, 16'hAAAA, 16'h5555,
              16'h7FFF, 16'h0001, 16'hFFFE};
        add_row(a, 1'b0, 16'd0, 16'd0, 16'd0, 1'b0);

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            c = directed_rows[i].crd;
            send_triangle(c, directed_rows[i], 1'b1);
        end
        push <= 1'b0;

        // Hold off until the block has drained everything
        while (expected_vertices.size() != 0)
            @(negedge clk);

        // Random triangles: full range, small triangles, collinear ones, copied coordinates
        for (int t = 0; t < RANDOM_TRIANGLES; t++)
        begin
            cls = $urandom_range(0, 9);
            foreach (c[i])
                c[i] = CW'($urandom);
            if (cls < 3)
            begin
                for (int i = 3; i < 9; i++)
                    c[i] = c[i % 3] + CW'($urandom_range(0, 8)) - CW'(4);
            end
            else if (cls == 3)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    base = CW'($urandom_range(0, 3)) - CW'(1);
                    c[3+i] = c[i] + base;
                    c[6+i] = c[i] + (base << 1);
                end
            end
            else if (cls == 4)
                c[6 + $urandom_range(0, 2)] = c[$urandom_range(0, 2)];
            send_triangle(c, none, 1'b0);
        end
        push <= 1'b0;

        while (expected_vertices.size() != 0)
            @(negedge clk);
        repeat (100) @(posedge clk);

        if (mismatches == 0 && expected_vertices.size() == 0)
            $display("flat_triangle_normal_expander verification clean");
        else
            $display("flat_triangle_normal_expander verification failed");
        $finish;
    end

endmodule
